[src/i2cm_pkg.sv]
`default_nettype none

package i2cm_pkg;

    // Raw command codes on the input channel.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [2:0] BIT_MSB = 3'd7;

    // Classified operation, as it travels through the queue.
    typedef enum logic [1:0] {
        OP_TICK,
        OP_WRITE,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] slave_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_SEND_DEV,
        PH_ACK_DEV,
        PH_SEND_REG,
        PH_ACK_REG,
        PH_SEND_DATA,
        PH_ACK_DATA,
        PH_RS_PREP,
        PH_RSTART,
        PH_SEND_RDEV,
        PH_ACK_RDEV,
        PH_RECV,
        PH_MNACK,
        PH_STOP,
        PH_STOP_END
    } phase_t;

endpackage

`default_nettype wire

[src/i2c_master_register_access_unit.sv]
// A tick accepted is first written into the tick queue; the engine then pops it and registers its result.
// Throughput: one tick per clock cycle, sustained while the output side takes results.
// The tick queue (QUEUE_DEPTH entries) lets input and output stall independently.
// Reset (rst_n low, asynchronous): bus sequencer idle, queue empty, no result pending,
// NACK flag and last read byte cleared; scl, sda, busy and done regs are not reset.
`default_nettype none

module i2c_master_register_access_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] command,
    input  wire logic [7:0] slave_addr,
    input  wire logic [7:0] reg_addr,
    input  wire logic [7:0] write_data,
    input  wire logic       sda_in,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            scl_out,
    output logic            sda_out,
    output logic            busy_res,
    output logic            done_res,
    output logic            nack_seen,
    output logic [7:0]      read_data
);

    logic            q_valid;
    logic            q_pop;
    i2cm_pkg::item_t q_item;

    i2cm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .slave_addr (slave_addr),
        .reg_addr   (reg_addr),
        .write_data (write_data),
        .sda_in     (sda_in),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    i2cm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .scl_out   (scl_out),
        .sda_out   (sda_out),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .nack_seen (nack_seen),
        .read_data (read_data)
    );

endmodule

`default_nettype wire

[src/i2cm_front.sv]
`default_nettype none

// Accepts ticks, classifies the command and holds them in a short queue.
module i2cm_front #(
    parameter int DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    command,
    input  wire logic [7:0]    slave_addr,
    input  wire logic [7:0]    reg_addr,
    input  wire logic [7:0]    write_data,
    input  wire logic          sda_in,
    output logic               q_valid,
    output i2cm_pkg::item_t    q_item,
    input  wire logic          q_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    i2cm_pkg::item_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    i2cm_pkg::item_t in_item;
    logic            push;

    always_comb
    begin
        in_item.slave_addr = slave_addr;
        in_item.reg_addr   = reg_addr;
        in_item.write_data = write_data;
        in_item.sda_in     = sda_in;
        case (command)
            i2cm_pkg::CMD_WRITE: in_item.op = i2cm_pkg::OP_WRITE;
            i2cm_pkg::CMD_READ:  in_item.op = i2cm_pkg::OP_READ;
            default:             in_item.op = i2cm_pkg::OP_TICK;
        endcase
    end

    assign in_ready = (count_reg != CW'(DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

[src/i2cm_engine.sv]
`default_nettype none

// Bus sequencer: takes one tick from the queue per cycle while the output slot is
// empty or being emptied, and registers the drive levels and status for that tick.
module i2cm_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire i2cm_pkg::item_t   q_item,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   scl_out,
    output logic                   sda_out,
    output logic                   busy_res,
    output logic                   done_res,
    output logic                   nack_seen,
    output logic [7:0]             read_data
);

    i2cm_pkg::phase_t phase_reg, phase_next, cur_ph;
    logic       half_reg, half_next;
    logic [2:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] slave_reg, slave_next;
    logic [7:0] regad_reg, regad_next;
    logic [7:0] data_reg, data_next;
    logic       is_read_reg, is_read_next;
    logic       nack_reg, nack_next;
    logic [7:0] last_read_reg, last_read_next;
    logic       out_valid_reg;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [7:0] recv_byte;
    i2cm_pkg::phase_t send_follow;

    // A new tick is taken whenever the output slot is empty or being emptied.
    assign q_pop = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        phase_next     = phase_reg;
        half_next      = half_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        slave_next     = slave_reg;
        regad_next     = regad_reg;
        data_next      = data_reg;
        is_read_next   = is_read_reg;
        nack_next      = nack_reg;
        last_read_next = last_read_reg;
        scl_next       = 1'b1;
        sda_next       = 1'b1;
        busy_next      = 1'b1;
        done_next      = 1'b0;
        recv_byte      = shift_reg;
        cur_ph         = phase_reg;
        send_follow    = i2cm_pkg::PH_IDLE;

        if (phase_reg == i2cm_pkg::PH_IDLE && q_item.op != i2cm_pkg::OP_TICK)
        begin
            slave_next   = q_item.slave_addr;
            regad_next   = q_item.reg_addr;
            data_next    = q_item.write_data;
            is_read_next = (q_item.op == i2cm_pkg::OP_READ);
            nack_next    = 1'b0;
            cur_ph       = i2cm_pkg::PH_START;
            half_next    = 1'b0;
            bit_next     = i2cm_pkg::BIT_MSB;
        end
        phase_next = cur_ph;

        case (cur_ph)
            i2cm_pkg::PH_SEND_DEV:  send_follow = i2cm_pkg::PH_ACK_DEV;
            i2cm_pkg::PH_SEND_REG:  send_follow = i2cm_pkg::PH_ACK_REG;
            i2cm_pkg::PH_SEND_DATA: send_follow = i2cm_pkg::PH_ACK_DATA;
            i2cm_pkg::PH_SEND_RDEV: send_follow = i2cm_pkg::PH_ACK_RDEV;
            i2cm_pkg::PH_RECV:      send_follow = i2cm_pkg::PH_MNACK;
            default:                send_follow = i2cm_pkg::PH_IDLE;
        endcase

        case (cur_ph)
            i2cm_pkg::PH_START,
            i2cm_pkg::PH_RSTART:
            begin
                scl_next = 1'b1;
                sda_next = !half_next;
                if (!half_next)
                begin
                    half_next = 1'b1;
                end
                else
                begin
                    half_next  = 1'b0;
                    bit_next   = i2cm_pkg::BIT_MSB;
                    if (cur_ph == i2cm_pkg::PH_START)
                    begin
                        phase_next = i2cm_pkg::PH_SEND_DEV;
                        shift_next = slave_next;
                    end
                    else
                    begin
                        phase_next = i2cm_pkg::PH_SEND_RDEV;
                        shift_next = slave_next | 8'h01;
                    end
                end
            end
            i2cm_pkg::PH_SEND_DEV,
            i2cm_pkg::PH_SEND_REG,
            i2cm_pkg::PH_SEND_DATA,
            i2cm_pkg::PH_SEND_RDEV,
            i2cm_pkg::PH_RECV:
            begin
                scl_next = half_next;
                if (cur_ph == i2cm_pkg::PH_RECV)
                begin
                    sda_next = 1'b1;
                    if (half_next && q_item.sda_in)
                    begin
                        recv_byte = shift_reg | (8'h01 << bit_next);
                    end
                    shift_next = recv_byte;
                    if (half_next && bit_next == '0)
                    begin
                        last_read_next = recv_byte;
                    end
                end
                else
                begin
                    sda_next = shift_reg[bit_next];
                end
                if (!half_next)
                begin
                    half_next = 1'b1;
                end
                else
                begin
                    half_next = 1'b0;
                    if (bit_next == '0)
                    begin
                        bit_next   = i2cm_pkg::BIT_MSB;
                        phase_next = send_follow;
                    end
                    else
                    begin
                        bit_next = bit_next - 1'b1;
                    end
                end
            end
            i2cm_pkg::PH_ACK_DEV,
            i2cm_pkg::PH_ACK_REG,
            i2cm_pkg::PH_ACK_DATA,
            i2cm_pkg::PH_ACK_RDEV:
            begin
                scl_next = half_next;
                sda_next = 1'b1;
                if (!half_next)
                begin
                    half_next = 1'b1;
                end
                else
                begin
                    if (q_item.sda_in)
                    begin
                        nack_next = 1'b1;
                    end
                    half_next = 1'b0;
                    if (cur_ph == i2cm_pkg::PH_ACK_DEV)
                    begin
                        phase_next = i2cm_pkg::PH_SEND_REG;
                        shift_next = regad_reg;
                        bit_next   = i2cm_pkg::BIT_MSB;
                    end
                    else if (cur_ph == i2cm_pkg::PH_ACK_REG)
                    begin
                        if (is_read_reg)
                        begin
                            phase_next = i2cm_pkg::PH_RS_PREP;
                        end
                        else
                        begin
                            phase_next = i2cm_pkg::PH_SEND_DATA;
                            shift_next = data_reg;
                            bit_next   = i2cm_pkg::BIT_MSB;
                        end
                    end
                    else if (cur_ph == i2cm_pkg::PH_ACK_DATA)
                    begin
                        phase_next = i2cm_pkg::PH_STOP;
                    end
                    else
                    begin
                        phase_next = i2cm_pkg::PH_RECV;
                        shift_next = '0;
                        bit_next   = i2cm_pkg::BIT_MSB;
                    end
                end
            end
            i2cm_pkg::PH_RS_PREP:
            begin
                scl_next   = 1'b0;
                sda_next   = 1'b1;
                phase_next = i2cm_pkg::PH_RSTART;
                half_next  = 1'b0;
            end
            i2cm_pkg::PH_MNACK,
            i2cm_pkg::PH_STOP:
            begin
                scl_next = half_next;
                sda_next = (cur_ph == i2cm_pkg::PH_MNACK);
                if (!half_next)
                begin
                    half_next = 1'b1;
                end
                else
                begin
                    half_next  = 1'b0;
                    phase_next = (cur_ph == i2cm_pkg::PH_MNACK) ? i2cm_pkg::PH_STOP
                                                                : i2cm_pkg::PH_STOP_END;
                end
            end
            i2cm_pkg::PH_STOP_END:
            begin
                scl_next   = 1'b1;
                sda_next   = 1'b1;
                done_next  = 1'b1;
                phase_next = i2cm_pkg::PH_IDLE;
                half_next  = 1'b0;
                bit_next   = i2cm_pkg::BIT_MSB;
            end
            default:
            begin
                phase_next = i2cm_pkg::PH_IDLE;
                half_next  = 1'b0;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2cm_pkg::PH_IDLE;
            half_reg      <= 1'b0;
            bit_reg       <= i2cm_pkg::BIT_MSB;
            shift_reg     <= '0;
            slave_reg     <= '0;
            regad_reg     <= '0;
            data_reg      <= '0;
            is_read_reg   <= 1'b0;
            nack_reg      <= 1'b0;
            last_read_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                half_reg      <= half_next;
                bit_reg       <= bit_next;
                shift_reg     <= shift_next;
                slave_reg     <= slave_next;
                regad_reg     <= regad_next;
                data_reg      <= data_next;
                is_read_reg   <= is_read_next;
                nack_reg      <= nack_next;
                last_read_reg <= last_read_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            scl_reg  <= scl_next;
            sda_reg  <= sda_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // The sticky status only changes when no result is held or the held result is
    // consumed, so it can drive the output directly.
    assign out_valid = out_valid_reg;
    assign scl_out   = scl_reg;
    assign sda_out   = sda_reg;
    assign busy_res  = busy_reg;
    assign done_res  = done_reg;
    assign nack_seen = nack_reg;
    assign read_data = last_read_reg;

endmodule

`default_nettype wire

[sim/i2c_master_register_access_unit_tb.sv]
`timescale 1ns / 1ps

module i2c_master_register_access_unit_tb;

    // A command value with no meaning; the block must treat it as a plain tick.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int HOLD_CYCLES = 60;
    localparam int IDLE_LIMIT  = 1000;
    localparam int TAIL_CYCLES = 8;
    localparam int ITEM_TARGET = 1000;

    // How the simulated slave drives SDA during a transfer.
    localparam int ACKS_LOW   = 0;
    localparam int ACKS_HIGH  = 1;
    localparam int ACKS_MIXED = 2;

    typedef struct packed {
        bit       scl;
        bit       sda;
        bit       busy;
        bit       done;
        bit       nack;
        bit [7:0] rdata;
    } bus_levels_t;

    class i2c_bus_scoreboard;
        i2cm_pkg::phase_t phase;
        bit               half;
        bit [2:0]         bit_idx;
        bit [7:0]         shifter;
        bit [7:0]         dev_byte;
        bit [7:0]         reg_byte;
        bit [7:0]         data_byte;
        bit               read_op;
        bit               nack_flag;
        bit [7:0]         last_byte;
        bus_levels_t      pending_levels[$];
        int               errors;

        function new();
            phase     = i2cm_pkg::PH_IDLE;
            half      = 1'b0;
            bit_idx   = i2cm_pkg::BIT_MSB;
            shifter   = '0;
            dev_byte  = '0;
            reg_byte  = '0;
            data_byte = '0;
            read_op   = 1'b0;
            nack_flag = 1'b0;
            last_byte = '0;
            errors    = 0;
        endfunction

        function bit busy();
            return phase != i2cm_pkg::PH_IDLE;
        endfunction

        function bit at_ack();
            return phase inside {i2cm_pkg::PH_ACK_DEV, i2cm_pkg::PH_ACK_REG,
                                 i2cm_pkg::PH_ACK_DATA, i2cm_pkg::PH_ACK_RDEV};
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction

        function void load_byte(i2cm_pkg::phase_t next_phase, bit [7:0] value);
            phase   = next_phase;
            shifter = value;
            bit_idx = i2cm_pkg::BIT_MSB;
            half    = 1'b0;
        endfunction

        function void step_bit(i2cm_pkg::phase_t next_phase);
            if (!half)
            begin
                half = 1'b1;
            end
            else
            begin
                half = 1'b0;
                if (bit_idx == 3'd0)
                begin
                    bit_idx = i2cm_pkg::BIT_MSB;
                    phase   = next_phase;
                end
                else
                begin
                    bit_idx = bit_idx - 3'd1;
                end
            end
        endfunction

        function void step_half(i2cm_pkg::phase_t next_phase);
            if (!half)
            begin
                half = 1'b1;
            end
            else
            begin
                half  = 1'b0;
                phase = next_phase;
            end
        endfunction

        // Advances the bus state by one accepted tick and queues the levels it must give.
        function void note_tick(logic [1:0] cmd, logic [7:0] sa, logic [7:0] ra,
                                logic [7:0] wd, logic sda_bit);
            bus_levels_t lv;
            lv = '{scl: 1'b1, sda: 1'b1, busy: 1'b1, done: 1'b0, nack: 1'b0, rdata: 8'h00};
            if (phase == i2cm_pkg::PH_IDLE &&
                (cmd == i2cm_pkg::CMD_WRITE || cmd == i2cm_pkg::CMD_READ))
            begin
                dev_byte  = sa;
                reg_byte  = ra;
                data_byte = wd;
                read_op   = (cmd == i2cm_pkg::CMD_READ);
                nack_flag = 1'b0;
                phase     = i2cm_pkg::PH_START;
                half      = 1'b0;
                bit_idx   = i2cm_pkg::BIT_MSB;
            end
            case (phase)
                i2cm_pkg::PH_START, i2cm_pkg::PH_RSTART:
                begin
                    lv.sda = !half;
                    if (!half)
                        half = 1'b1;
                    else if (phase == i2cm_pkg::PH_START)
                        load_byte(i2cm_pkg::PH_SEND_DEV, dev_byte);
                    else
                        load_byte(i2cm_pkg::PH_SEND_RDEV, dev_byte | 8'h01);
                end
                i2cm_pkg::PH_SEND_DEV, i2cm_pkg::PH_SEND_REG,
                i2cm_pkg::PH_SEND_DATA, i2cm_pkg::PH_SEND_RDEV:
                begin
                    lv.scl = half;
                    lv.sda = shifter[bit_idx];
                    case (phase)
                        i2cm_pkg::PH_SEND_DEV:  step_bit(i2cm_pkg::PH_ACK_DEV);
                        i2cm_pkg::PH_SEND_REG:  step_bit(i2cm_pkg::PH_ACK_REG);
                        i2cm_pkg::PH_SEND_DATA: step_bit(i2cm_pkg::PH_ACK_DATA);
                        default:                step_bit(i2cm_pkg::PH_ACK_RDEV);
                    endcase
                end
                i2cm_pkg::PH_ACK_DEV, i2cm_pkg::PH_ACK_REG,
                i2cm_pkg::PH_ACK_DATA, i2cm_pkg::PH_ACK_RDEV:
                begin
                    lv.scl = half;
                    if (!half)
                    begin
                        half = 1'b1;
                    end
                    else
                    begin
                        if (sda_bit)
                            nack_flag = 1'b1;
                        half = 1'b0;
                        case (phase)
                            i2cm_pkg::PH_ACK_DEV: load_byte(i2cm_pkg::PH_SEND_REG, reg_byte);
                            i2cm_pkg::PH_ACK_REG:
                            begin
                                if (read_op)
                                    phase = i2cm_pkg::PH_RS_PREP;
                                else
                                    load_byte(i2cm_pkg::PH_SEND_DATA, data_byte);
                            end
                            i2cm_pkg::PH_ACK_DATA: phase = i2cm_pkg::PH_STOP;
                            default:
                            begin
                                phase   = i2cm_pkg::PH_RECV;
                                shifter = '0;
                                bit_idx = i2cm_pkg::BIT_MSB;
                            end
                        endcase
                    end
                end
                i2cm_pkg::PH_RS_PREP:
                begin
                    lv.scl = 1'b0;
                    phase  = i2cm_pkg::PH_RSTART;
                    half   = 1'b0;
                end
                i2cm_pkg::PH_RECV:
                begin
                    lv.scl = half;
                    if (half && sda_bit)
                        shifter[bit_idx] = 1'b1;
                    if (half && bit_idx == 3'd0)
                        last_byte = shifter;
                    step_bit(i2cm_pkg::PH_MNACK);
                end
                i2cm_pkg::PH_MNACK:
                begin
                    lv.scl = half;
                    step_half(i2cm_pkg::PH_STOP);
                end
                i2cm_pkg::PH_STOP:
                begin
                    lv.scl = half;
                    lv.sda = 1'b0;
                    step_half(i2cm_pkg::PH_STOP_END);
                end
                i2cm_pkg::PH_STOP_END:
                begin
                    lv.done = 1'b1;
                    phase   = i2cm_pkg::PH_IDLE;
                    half    = 1'b0;
                    bit_idx = i2cm_pkg::BIT_MSB;
                end
                default:
                begin
                    phase   = i2cm_pkg::PH_IDLE;
                    half    = 1'b0;
                    lv.busy = 1'b0;
                end
            endcase
            lv.nack  = nack_flag;
            lv.rdata = last_byte;
            pending_levels.push_back(lv);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_levels(bus_levels_t got);
            bus_levels_t want;
            if (pending_levels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end
            else
            begin
                want = pending_levels.pop_front();
                compare_field("scl_out", want.scl, got.scl);
                compare_field("sda_out", want.sda, got.sda);
                compare_field("busy_res", want.busy, got.busy);
                compare_field("done_res", want.done, got.done);
                compare_field("nack_seen", want.nack, got.nack);
                compare_field("read_data", want.rdata, got.rdata);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] command;
    logic [7:0] slave_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
    logic       out_valid;
    logic       out_ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       nack_seen;
    logic [7:0] read_data;

    i2c_bus_scoreboard sb = new();
    int  items_sent;
    int  idle_cycles;
    bit  steady;
    bit  hold_req;

    i2c_master_register_access_unit i_dut (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 6);
        else
            return $urandom_range(10, 30);
    endfunction

    // Returns at the rising edge where the transaction is taken.
    task automatic offer_tick(input logic [1:0] cmd, input logic [7:0] sa, input logic [7:0] ra,
                              input logic [7:0] wd, input logic sda_bit);
        int gap;
        gap = steady ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        command    <= cmd;
        slave_addr <= sa;
        reg_addr   <= ra;
        write_data <= wd;
        sda_in     <= sda_bit;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_tick(cmd, sa, ra, wd, sda_bit);
        items_sent++;
    endtask

    task automatic run_transfer(input logic [1:0] cmd, input logic [7:0] sa, input logic [7:0] ra,
                                input logic [7:0] wd, input int ack_style, input int noise_pct);
        logic [1:0] tick_cmd;
        logic       level;
        offer_tick(cmd, sa, ra, wd, 1'($urandom));
        while (sb.busy())
        begin
            if ($urandom_range(0, 99) < noise_pct)
                tick_cmd = 2'($urandom_range(0, 3));
            else
                tick_cmd = i2cm_pkg::CMD_TICK;
            case (ack_style)
                ACKS_LOW:  level = 1'b0;
                ACKS_HIGH: level = 1'b1;
                default:   level = sb.at_ack() ? ($urandom_range(0, 9) == 0) : 1'($urandom);
            endcase
            offer_tick(tick_cmd, 8'($urandom), 8'($urandom), 8'($urandom), level);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!steady)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_levels('{scl: scl_out, sda: sda_out, busy: busy_res, done: done_res,
                              nack: nack_seen, rdata: read_data});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("i2c_master_register_access_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        bit mid_hold_done;
        int idle_ticks;
        mid_hold_done = 1'b0;
        items_sent    = 0;
        idle_cycles   = 0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = i2cm_pkg::CMD_TICK;
        slave_addr    = '0;
        reg_addr      = '0;
        write_data    = '0;
        sda_in        = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Idle bus with both SDA levels and the unused command value.
        offer_tick(i2cm_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        offer_tick(i2cm_pkg::CMD_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        offer_tick(CMD_SPARE, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        offer_tick(CMD_SPARE, 8'h00, 8'h00, 8'h00, 1'b0);
        // All-ones write with clean acks, then commands thrown at a busy block.
        run_transfer(i2cm_pkg::CMD_WRITE, 8'hFF, 8'hFF, 8'hFF, ACKS_LOW, 30);
        // All-zeros read against a silent bus: every ack missed, byte reads as all ones.
        run_transfer(i2cm_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, ACKS_HIGH, 0);
        // A read of zeros, then a write starting on the very next tick after done.
        run_transfer(i2cm_pkg::CMD_READ, 8'hA5, 8'h5A, 8'hFF, ACKS_LOW, 0);
        run_transfer(i2cm_pkg::CMD_WRITE, 8'h00, 8'h00, 8'h00, ACKS_HIGH, 0);
        drain_results();

        hold_req = 1'b1;
        while (items_sent < ITEM_TARGET)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if (!mid_hold_done && items_sent >= ITEM_TARGET / 2)
            begin
                mid_hold_done = 1'b1;
                hold_req      = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
                drain_results();
            idle_ticks = $urandom_range(0, 3);
            repeat (idle_ticks)
                offer_tick(($urandom_range(0, 1) == 0) ? i2cm_pkg::CMD_TICK : CMD_SPARE,
                           8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
            run_transfer(($urandom_range(0, 1) == 0) ? i2cm_pkg::CMD_WRITE
                                                     : i2cm_pkg::CMD_READ,
                         8'($urandom), 8'($urandom), 8'($urandom),
                         ($urandom_range(0, 9) == 0) ? ACKS_HIGH : ACKS_MIXED,
                         ($urandom_range(0, 3) == 0) ? 15 : 0);
        end
        steady = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("i2c_master_register_access_unit regression: pass");
        else
            $display("i2c_master_register_access_unit regression: fail");
        $finish;
    end

endmodule

[i2c_master_register_access_unit.f]
src/i2cm_pkg.sv
src/i2cm_front.sv
src/i2cm_engine.sv
src/i2c_master_register_access_unit.sv
sim/i2c_master_register_access_unit_tb.sv
